// ----- design/atb_pkg.sv -----
`timescale 1ns / 1ps

package atb_pkg;

  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam int CMD_W    = 8;
  localparam int CHAN_W   = 8;
  localparam int HANDLE_W = 16;
  localparam int RETRY_W  = 5;
  localparam int LIMIT_W  = 4;
  localparam int FREED_W  = 4;

  localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RESET = 4'd10;
  localparam logic [RETRY_W-1:0] RETRY_MAX         = 5'd31;
  localparam logic [FREED_W-1:0] FREED_MAX         = 4'd15;

  typedef enum logic [1:0] {
    REQ_SEND = 2'd0,
    REQ_ACK  = 2'd1,
    REQ_TICK = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    RES_FIRST = 2'd0,
    RES_RETX  = 2'd1,
    RES_ACK   = 2'd2,
    RES_EMPTY = 2'd3
  } res_kind_t;

  typedef struct packed {
    res_kind_t             kind;
    logic [CMD_W-1:0]      cmd;
    logic [CHAN_W-1:0]     chan;
    logic [HANDLE_W-1:0]   handle;
    logic                  stored;
    logic                  dropped;
    logic [FREED_W-1:0]    freed;
    logic                  last;
  } result_t;

  typedef struct packed {
    logic    vld;
    result_t res;
  } res_push_t;

endpackage

// ----- design/atb_engine.sv -----
`timescale 1ns / 1ps

module atb_engine
  import atb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [CHAN_W-1:0]   in_chan,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic [LIMIT_W-1:0]  retry_limit,
  input  logic                out_rdy,
  output res_push_t           push
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FINAL = 3'b100
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [CHAN_W-1:0]   chan;
    logic [HANDLE_W-1:0] handle;
    logic [RETRY_W-1:0]  retries;
  } entry_t;

  state_t              state;
  logic [SLOTS-1:0]    valid;
  logic [1:0]          req;
  logic [CMD_W-1:0]    cmd_r;
  logic [CHAN_W-1:0]   chan_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [FREED_W-1:0]  freed;
  logic [SLOT_W-1:0]   last_idx;
  logic [CNT_W-1:0]    iss_cnt;
  logic                p_vld;
  logic [SLOT_W-1:0]   p_idx;

  entry_t mem [SLOTS];
  entry_t rd_data;

  logic [SLOT_W-1:0]  free_idx;
  logic [SLOT_W-1:0]  top_idx;
  logic               has_free;
  logic               iss_more;
  logic               p_live;
  logic               p_match;
  logic [RETRY_W-1:0] new_retries;
  logic               drop;
  logic               p_emit;
  logic               advance;
  logic               rd_en;
  logic               walk_end;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_idx;
  entry_t             wr_data;

  assign in_ready = (state == ST_IDLE);
  assign has_free = ~&valid;

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) free_idx = SLOT_W'(i);
    end
  end

  // Highest pending slot at the tick marks which resend carries the last flag.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (valid[i]) top_idx = SLOT_W'(i);
    end
  end

  assign iss_more    = (iss_cnt < CNT_W'(SLOTS));
  assign p_live      = p_vld && valid[p_idx];
  assign p_match     = (rd_data.cmd == cmd_r) && (rd_data.chan == chan_r);
  assign new_retries = (rd_data.retries == RETRY_MAX) ? RETRY_MAX :
                       rd_data.retries + RETRY_W'(1);
  assign drop        = new_retries > {1'b0, retry_limit};
  assign p_emit      = p_live && (req == REQ_TICK);
  assign advance     = !p_emit || out_rdy;
  assign rd_en       = (state == ST_WALK) && iss_more && advance;
  assign walk_end    = !iss_more && (!p_vld || advance);

  always_comb begin
    push = '0;
    if (state == ST_FINAL) begin
      push.vld = out_rdy;
      push.res.last = 1'b1;
      case (req)
        REQ_SEND: begin
          push.res.kind   = RES_FIRST;
          push.res.cmd    = cmd_r;
          push.res.chan   = chan_r;
          push.res.handle = handle_r;
          push.res.stored = has_free;
        end
        REQ_ACK: begin
          push.res.kind  = RES_ACK;
          push.res.cmd   = cmd_r;
          push.res.chan  = chan_r;
          push.res.freed = freed;
        end
        default: begin
          push.res.kind = RES_EMPTY;
        end
      endcase
    end else if (state == ST_WALK) begin
      push.vld = p_emit && out_rdy;
      push.res.kind    = RES_RETX;
      push.res.cmd     = rd_data.cmd;
      push.res.chan    = rd_data.chan;
      push.res.handle  = rd_data.handle;
      push.res.dropped = drop;
      push.res.last    = (p_idx == last_idx);
    end
  end

  // Reads run one slot ahead of the write-back, so the two never meet.
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = p_idx;
    wr_data = '{cmd: rd_data.cmd, chan: rd_data.chan, handle: rd_data.handle,
                retries: new_retries};
    if (state == ST_FINAL && req == REQ_SEND) begin
      wr_en   = out_rdy && has_free;
      wr_idx  = free_idx;
      wr_data = '{cmd: cmd_r, chan: chan_r, handle: handle_r, retries: '0};
    end else if (state == ST_WALK) begin
      wr_en = p_emit && out_rdy && !drop;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[iss_cnt[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req      <= in_req;
      cmd_r    <= in_cmd;
      chan_r   <= in_chan;
      handle_r <= in_handle;
      freed    <= '0;
      last_idx <= top_idx;
    end else if (state == ST_WALK && p_live && req == REQ_ACK && p_match) begin
      if (freed != FREED_MAX) freed <= freed + FREED_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      valid   <= '0;
      iss_cnt <= '0;
      p_vld   <= 1'b0;
      p_idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          iss_cnt <= '0;
          p_vld   <= 1'b0;
          if (in_valid) begin
            case (in_req)
              REQ_SEND: state <= ST_FINAL;
              REQ_ACK:  state <= ST_WALK;
              REQ_TICK: state <= (valid == '0) ? ST_FINAL : ST_WALK;
              default:  state <= ST_IDLE;
            endcase
          end
        end
        ST_WALK: begin
          if (advance) begin
            p_vld <= rd_en;
            p_idx <= iss_cnt[SLOT_W-1:0];
            if (rd_en) iss_cnt <= iss_cnt + CNT_W'(1);
            if (p_live) begin
              if ((req == REQ_ACK && p_match) || (req == REQ_TICK && drop)) begin
                valid[p_idx] <= 1'b0;
              end
            end
          end
          if (walk_end) begin
            state <= (req == REQ_ACK) ? ST_FINAL : ST_IDLE;
          end
        end
        ST_FINAL: begin
          if (out_rdy) begin
            if (req == REQ_SEND && has_free) valid[free_idx] <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_pipe_in_walk: assert property (@(posedge clk) disable iff (rst)
    p_vld |-> state == ST_WALK)
    else $error("slot read pending outside of a table walk");

  a_send_claims_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL && req == REQ_SEND && out_rdy && has_free)
      |=> $countones(valid) == $past($countones(valid)) + 1)
    else $error("stored send did not take exactly one slot");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (push.vld && push.res.last) |=> !push.vld)
    else $error("word pushed after the last word of an item");
`endif

endmodule

// ----- design/atb_out_buf.sv -----
`timescale 1ns / 1ps

module atb_out_buf
  import atb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  res_push_t push,
  output logic      out_rdy,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_res
);

  assign out_rdy = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_rdy) begin
      out_valid <= push.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && push.vld) begin
      out_res <= push.res;
    end
  end

endmodule

// ----- design/ack_retransmit_table.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Content
// s_axis    in   tuser[1:0] req_type; tdata cmd_code, chan_no, frame_handle
// m_axis    out  tuser[1:0] result_kind; tdata result fields; tlast last
// cfg       in   cfg_wr_en, cfg_wr_data = retry_limit
//
// A send gives one word. An ack walks all SLOTS entries of the slot memory
// through its single read port. A tick walks the same way and gives one resend
// word per pending slot; a tick on an empty table gives one empty word.
// Reset clears the valid bits at once; no clearing pass is run. retry_limit
// resets to 10. A stalled output holds the walk; a new word is accepted while
// the output register still holds the previous result only if m_tready takes it.

module ack_retransmit_table
  import atb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [31:0]         s_tdata,   // cmd_code[7:0], chan_no[15:8], frame_handle[31:16]
  input  logic [1:0]          s_tuser,   // req_type[1:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [39:0]         m_tdata,   // out_cmd[7:0], out_chan[15:8], out_handle[31:16],
                                         // stored[32], dropped[33], freed_count[37:34]
  output logic [1:0]          m_tuser,   // result_kind[1:0]
  output logic                m_tlast,
  input  logic                cfg_wr_en,
  input  logic [LIMIT_W-1:0]  cfg_wr_data
);

  logic [LIMIT_W-1:0] retry_limit;
  logic               out_rdy;
  res_push_t          push;
  result_t            out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= RETRY_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      retry_limit <= cfg_wr_data;
    end
  end

  atb_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_req      (s_tuser),
    .in_cmd      (s_tdata[7:0]),
    .in_chan     (s_tdata[15:8]),
    .in_handle   (s_tdata[31:16]),
    .retry_limit (retry_limit),
    .out_rdy     (out_rdy),
    .push        (push)
  );

  atb_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_rdy   (out_rdy),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {2'b00, out_res.freed, out_res.dropped, out_res.stored,
                    out_res.handle, out_res.chan, out_res.cmd};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
  import atb_pkg::*;
();

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES  = 2 * SLOTS + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 76;
  localparam int NUM_PHASES     = 6;

  // Predicts the words of the retransmit table and checks them in order.
  class retx_checker;
    logic                slot_used    [SLOTS];
    logic [CMD_W-1:0]    slot_cmd     [SLOTS];
    logic [CHAN_W-1:0]   slot_chan    [SLOTS];
    logic [HANDLE_W-1:0] slot_handle  [SLOTS];
    logic [RETRY_W-1:0]  slot_retries [SLOTS];
    int                  used_count;
    logic [LIMIT_W-1:0]  limit;
    result_t             expected_words[$];
    int                  errors;

    function void clear_table();
      for (int s = 0; s < SLOTS; s++) begin
        slot_used[s]    = 1'b0;
        slot_retries[s] = '0;
      end
      used_count = 0;
      limit      = RETRY_LIMIT_RESET;
      errors     = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      limit = value;
    endfunction

    function int pending_results();
      return expected_words.size();
    endfunction

    function result_t make_word(res_kind_t kind, logic [CMD_W-1:0] cmd,
                                logic [CHAN_W-1:0] chan, logic [HANDLE_W-1:0] handle,
                                logic stored, logic dropped,
                                logic [FREED_W-1:0] freed, logic last);
      result_t w;
      w.kind    = kind;
      w.cmd     = cmd;
      w.chan    = chan;
      w.handle  = handle;
      w.stored  = stored;
      w.dropped = dropped;
      w.freed   = freed;
      w.last    = last;
      return w;
    endfunction

    function void note_request(logic [1:0] req, logic [CMD_W-1:0] cmd,
                               logic [CHAN_W-1:0] chan, logic [HANDLE_W-1:0] handle);
      logic took;
      logic drop;
      int   freed;
      took  = 1'b0;
      freed = 0;
      case (req)
        REQ_SEND: begin
          if (used_count < SLOTS) begin
            for (int s = 0; s < SLOTS && !took; s++) begin
              if (!slot_used[s]) begin
                slot_used[s]    = 1'b1;
                slot_cmd[s]     = cmd;
                slot_chan[s]    = chan;
                slot_handle[s]  = handle;
                slot_retries[s] = '0;
                used_count++;
                took = 1'b1;
              end
            end
          end
          expected_words.push_back(make_word(RES_FIRST, cmd, chan, handle, took, 1'b0,
                                             '0, 1'b1));
        end
        REQ_ACK: begin
          for (int s = 0; s < SLOTS; s++) begin
            if (slot_used[s] && slot_cmd[s] == cmd && slot_chan[s] == chan) begin
              slot_used[s]    = 1'b0;
              slot_retries[s] = '0;
              used_count--;
              freed++;
            end
          end
          if (freed > FREED_MAX) freed = int'(FREED_MAX);
          expected_words.push_back(make_word(RES_ACK, cmd, chan, '0, 1'b0, 1'b0,
                                             freed[FREED_W-1:0], 1'b1));
        end
        REQ_TICK: begin
          if (used_count == 0) begin
            expected_words.push_back(make_word(RES_EMPTY, '0, '0, '0, 1'b0, 1'b0, '0, 1'b1));
          end else begin
            for (int s = 0; s < SLOTS; s++) begin
              if (slot_used[s]) begin
                if (slot_retries[s] < RETRY_MAX) slot_retries[s]++;
                drop = (slot_retries[s] > {1'b0, limit});
                expected_words.push_back(make_word(RES_RETX, slot_cmd[s], slot_chan[s],
                                                   slot_handle[s], 1'b0, drop, '0, 1'b0));
                if (drop) begin
                  slot_used[s]    = 1'b0;
                  slot_retries[s] = '0;
                  used_count--;
                end
              end
            end
            expected_words[expected_words.size() - 1].last = 1'b1;
          end
        end
        default: begin
          // An unused request type leaves the table alone and gives no word.
        end
      endcase
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual kind %0d cmd %0h chan %0h",
                 $time, got.kind, got.cmd, got.chan);
        return;
      end
      want = expected_words.pop_front();
      check_field("result_kind", 32'(want.kind), 32'(got.kind));
      check_field("out_cmd", 32'(want.cmd), 32'(got.cmd));
      check_field("out_chan", 32'(want.chan), 32'(got.chan));
      check_field("out_handle", 32'(want.handle), 32'(got.handle));
      check_field("stored", 32'(want.stored), 32'(got.stored));
      check_field("dropped", 32'(want.dropped), 32'(got.dropped));
      check_field("freed_count", 32'(want.freed), 32'(got.freed));
      check_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [31:0]        s_tdata = '0;
  logic [1:0]         s_tuser = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [39:0]        m_tdata;
  logic [1:0]         m_tuser;
  logic               m_tlast;
  logic               cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0] cfg_wr_data = '0;

  bit          no_stall = 1'b0;
  retx_checker sb;
  result_t     word_seen;
  int          idle_cycles;

  ack_retransmit_table u_dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_req(input logic [1:0] req, input logic [CMD_W-1:0] cmd,
                          input logic [CHAN_W-1:0] chan, input logic [HANDLE_W-1:0] handle);
    @(negedge clk);
    while (!no_stall && $urandom_range(0, 99) < 11) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {handle, chan, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(req, cmd, chan, handle);
  endtask

  task automatic release_bus();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained(input int settle);
    while (sb.pending_results() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_limit(value);
  endtask

  // Output side: stall at random, except during the quiet phase.
  initial begin
    forever begin
      @(negedge clk);
      m_tready <= no_stall || ($urandom_range(0, 99) >= 11);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      word_seen.kind    = res_kind_t'(m_tuser);
      word_seen.cmd     = m_tdata[7:0];
      word_seen.chan    = m_tdata[15:8];
      word_seen.handle  = m_tdata[31:16];
      word_seen.stored  = m_tdata[32];
      word_seen.dropped = m_tdata[33];
      word_seen.freed   = m_tdata[37:34];
      word_seen.last    = m_tlast;
      sb.check_word(word_seen);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    logic [LIMIT_W-1:0] limits [NUM_PHASES];
    logic [CMD_W-1:0]   pool_cmd [3];
    logic [CHAN_W-1:0]  pool_chan [3];
    int                 n;
    int                 r;
    int                 p;
    bit                 paused;

    sb = new;
    sb.clear_table();
    limits    = '{4'd0, 4'd15, 4'd3, 4'd0, 4'd1, 4'd10};
    limits[3] = LIMIT_W'($urandom_range(0, 15));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, with a limit of one so that the third tick drops entries.
    write_limit(4'd1);
    send_req(REQ_TICK, 8'h00, 8'h00, 16'h0000);
    send_req(REQ_ACK, 8'h00, 8'h00, 16'hFFFF);
    send_req(REQ_SEND, 8'h00, 8'h00, 16'h0000);
    send_req(REQ_SEND, 8'hFF, 8'hFF, 16'hFFFF);
    repeat (6) send_req(REQ_SEND, 8'h5A, 8'hA5, HANDLE_W'($urandom_range(0, 65535)));
    // The table is full now, so this command goes out without being kept.
    send_req(REQ_SEND, 8'hC3, 8'h3C, 16'h1234);
    send_req(REQ_ACK, 8'h5A, 8'h00, 16'h0000);
    send_req(REQ_ACK, 8'h5A, 8'hA5, 16'h0000);
    send_req(REQ_TICK, 8'h00, 8'h00, 16'h0000);
    send_req(REQ_TICK, 8'hFF, 8'hFF, 16'hFFFF);
    send_req(REQ_TICK, 8'h00, 8'h00, 16'h0000);
    send_req(REQ_UNUSED, 8'hFF, 8'hFF, 16'hFFFF);
    repeat (SLOTS) send_req(REQ_SEND, 8'h81, 8'h18, HANDLE_W'($urandom_range(0, 65535)));
    send_req(REQ_ACK, 8'h81, 8'h18, 16'h0000);
    release_bus();
    wait_drained(SETTLE_CYCLES);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_limit(limits[phase]);
      no_stall = (phase == 2);
      for (int k = 0; k < 3; k++) begin
        pool_cmd[k]  = CMD_W'($urandom_range(0, 255));
        pool_chan[k] = CHAN_W'($urandom_range(0, 255));
      end
      n      = 0;
      paused = 1'b0;
      while (n < PHASE_ITEMS) begin
        // Halfway through, let the table answer everything before going on.
        if (n == PHASE_ITEMS / 2 && !paused) begin
          release_bus();
          wait_drained(0);
          paused = 1'b1;
        end
        r = $urandom_range(0, 99);
        p = $urandom_range(0, 2);
        if (r < 5) begin
          send_req(REQ_UNUSED, CMD_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                   HANDLE_W'($urandom_range(0, 65535)));
        end else if (r < 50) begin
          if ($urandom_range(0, 3) != 0)
            send_req(REQ_SEND, pool_cmd[p], pool_chan[p], HANDLE_W'($urandom_range(0, 65535)));
          else
            send_req(REQ_SEND, CMD_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                     HANDLE_W'($urandom_range(0, 65535)));
          n++;
        end else if (r < 75) begin
          if ($urandom_range(0, 9) < 7)
            send_req(REQ_ACK, pool_cmd[p], pool_chan[p], HANDLE_W'($urandom_range(0, 65535)));
          else
            send_req(REQ_ACK, CMD_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                     HANDLE_W'($urandom_range(0, 65535)));
          n++;
        end else begin
          send_req(REQ_TICK, CMD_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                   HANDLE_W'($urandom_range(0, 65535)));
          n++;
        end
      end
      release_bus();
      wait_drained(SETTLE_CYCLES);
    end
    no_stall = 1'b0;

    if (sb.errors == 0 && sb.pending_results() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
